FILE: design/tlg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_pkg
// shared sizes, cell and command codes, row type and controller states for
// the toroidal life grid engine
// ----------------------------------------------------------------------------
package tlg_pkg;

  // grid storage limits
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int CELL_W   = 2;
  localparam int DIM_W    = 7;
  localparam int COUNT_W  = 13;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int COL_AW   = $clog2(MAX_COLS);

  // request field widths
  localparam int FUNC_W   = 2;
  localparam int ROW_IDX_W = 6;
  localparam int COL_IDX_W = 6;

  // stream widths, whole bytes
  localparam int IN_W     = 16;
  localparam int OUT_W    = 48;
  localparam int OUT_USED = CELL_W + 3 * COUNT_W;

  // config port
  localparam int CFG_AW   = 1;
  localparam int CFG_DW   = 7;

  // popcount groups for the tally sweep
  localparam int GRP_SIZE  = 8;
  localparam int NUM_GRP   = (MAX_COLS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_CNT_W = $clog2(GRP_SIZE + 1);

  typedef logic [CELL_W-1:0] cell_t;
  typedef cell_t [MAX_COLS-1:0] row_t;

  localparam cell_t CELL_DEAD     = 2'd0;
  localparam cell_t CELL_ALIVE    = 2'd1;
  localparam cell_t CELL_OBSTACLE = 2'd2;

  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;

  localparam logic [CFG_AW-1:0] REG_ROW_COUNT = 1'd0;
  localparam logic [CFG_AW-1:0] REG_COL_COUNT = 1'd1;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OP_RD,
    ST_OP_MOD,
    ST_GEN_P0,
    ST_GEN_P1,
    ST_GEN_P2,
    ST_GEN_NX,
    ST_GEN_WR,
    ST_CNT,
    ST_DONE
  } state_t;

  // zero acts as one, above the limit acts as the limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

FILE: design/tlg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tlg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/tlg_row_next.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_row_next
// next generation of one grid row from the old rows above, at and below
// ----------------------------------------------------------------------------
module tlg_row_next import tlg_pkg::*; (
  input  row_t             prev_row,
  input  row_t             cur_row,
  input  row_t             next_row,
  input  logic [DIM_W-1:0] cols,
  output row_t             new_row
);

  logic [MAX_COLS-1:0] pa, ca, na;
  logic [COL_AW-1:0]   last_col;
  logic                wp, wc, wn;

  assign last_col = COL_AW'(cols - DIM_W'(1));

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      pa[c] = (prev_row[c] == CELL_ALIVE);
      ca[c] = (cur_row[c] == CELL_ALIVE);
      na[c] = (next_row[c] == CELL_ALIVE);
    end
  end

  // left neighbors of column zero wrap to the last active column
  assign wp = pa[last_col];
  assign wc = ca[last_col];
  assign wn = na[last_col];

  always_comb begin
    logic       lp, lc, ln, rp, rc, rn;
    logic [3:0] n;
    cell_t      s;
    for (int c = 0; c < MAX_COLS; c++) begin
      lp = (c == 0) ? wp : pa[(c + MAX_COLS - 1) % MAX_COLS];
      lc = (c == 0) ? wc : ca[(c + MAX_COLS - 1) % MAX_COLS];
      ln = (c == 0) ? wn : na[(c + MAX_COLS - 1) % MAX_COLS];
      rp = (DIM_W'(c + 1) == cols) ? pa[0] : pa[(c + 1) % MAX_COLS];
      rc = (DIM_W'(c + 1) == cols) ? ca[0] : ca[(c + 1) % MAX_COLS];
      rn = (DIM_W'(c + 1) == cols) ? na[0] : na[(c + 1) % MAX_COLS];
      n  = 4'(lp) + 4'(pa[c]) + 4'(rp) + 4'(lc) + 4'(rc)
         + 4'(ln) + 4'(na[c]) + 4'(rn);
      s  = cur_row[c];
      new_row[c] = s;
      if (DIM_W'(c) < cols) begin
        case (s)
          CELL_ALIVE: begin
            if (n < 4'd2 || n > 4'd3) begin
              new_row[c] = CELL_DEAD;
            end
          end
          CELL_DEAD: begin
            if (n == 4'd3) begin
              new_row[c] = CELL_ALIVE;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: design/toroidal_life_grid_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_life_grid_engine
// game of life grid with toroidal wrap, cell write and read, one result
// per request with alive, dead and total counts of the active area
// ----------------------------------------------------------------------------
// The grid lives in one row-wide ram (one word per row, two bits per cell),
// so every operation walks rows through its single read port. After reset a
// clearing pass writes all MAX_ROWS (64) rows to dead, with in_tready low;
// config writes are taken meanwhile. One request is worked at a time. A
// cell write, read or unused command reads its row, writes it back for a
// valid write, then runs the tally sweep over the active rows before
// out_tvalid; a generation reads the last row, row zero and the row below
// it, updates the rows in turn (ST_GEN_NX, ST_GEN_WR), then runs the tally
// sweep. The ram read port gives one row per cycle. The result sits in an
// output register, so a finished result waiting on out_tready does not hold
// off the next request; only the final tally hand-off waits for the output
// slot. Config must be written only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module toroidal_life_grid_engine import tlg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // config write port
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  // request stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // func, row, col, cell_state_in
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata   // cell_state_out, alive_count,
                                        // dead_count, total_cells, zero pad
);

  // request fields
  logic [FUNC_W-1:0]    in_func;
  logic [ROW_IDX_W-1:0] in_row;
  logic [COL_IDX_W-1:0] in_col;
  cell_t                in_val;

  assign in_func = in_tdata[1:0];
  assign in_row  = in_tdata[7:2];
  assign in_col  = in_tdata[13:8];
  assign in_val  = in_tdata[15:14];

  state_t state_r, state_nxt;

  // config registers and clamped area
  logic [DIM_W-1:0] row_count_r, col_count_r;
  logic [DIM_W-1:0] rows_eff, cols_eff;

  assign rows_eff = clamp_dim(row_count_r, DIM_W'(MAX_ROWS));
  assign cols_eff = clamp_dim(col_count_r, DIM_W'(MAX_COLS));

  // captured request
  logic [FUNC_W-1:0]    func_r;
  logic [ROW_IDX_W-1:0] row_r;
  logic [COL_IDX_W-1:0] col_r;
  cell_t                val_r;
  cell_t                rd_cell_r;
  logic                 in_area;

  assign in_area = (DIM_W'(row_r) < rows_eff) && (DIM_W'(col_r) < cols_eff);

  // ram ports
  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr, ram_raddr;
  row_t              ram_wdata, ram_rdata;

  // clearing pass
  logic [ROW_AW-1:0] clr_row_r;

  // generation window: old rows above, at and below, plus old row zero
  row_t             prev_r, cur_r, next_r, keep_r;
  logic             use_keep_r;
  logic [DIM_W-1:0] gen_row_r;
  logic [DIM_W-1:0] gen_nn, gen_nidx, gen_nidx0;
  logic             gen_last;
  row_t             new_row;

  assign gen_last  = (gen_row_r == rows_eff - DIM_W'(1));
  assign gen_nn    = gen_row_r + DIM_W'(2);
  assign gen_nidx  = (gen_nn >= rows_eff) ? '0 : gen_nn;
  assign gen_nidx0 = (rows_eff == DIM_W'(1)) ? '0 : DIM_W'(1);

  // tally sweep
  logic [DIM_W-1:0]     cnt_row_r;
  logic                 cnt_issue, cnt_start;
  logic                 rd_vld_r, grp_vld_r;
  logic [GRP_CNT_W-1:0] alive_part [NUM_GRP];
  logic [GRP_CNT_W-1:0] dead_part  [NUM_GRP];
  logic [GRP_CNT_W-1:0] alive_part_r [NUM_GRP];
  logic [GRP_CNT_W-1:0] dead_part_r  [NUM_GRP];
  logic [COUNT_W-1:0]   alive_acc_r, dead_acc_r;
  logic [COUNT_W-1:0]   alive_sum, dead_sum;

  assign cnt_issue = (state_r == ST_CNT) && (cnt_row_r < rows_eff);
  assign cnt_start = (state_nxt == ST_CNT) && (state_r != ST_CNT);

  // output register
  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_data_r;
  logic             out_load;
  logic [COUNT_W-1:0] total_cells;

  assign out_load    = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);
  assign total_cells = COUNT_W'(rows_eff) * COUNT_W'(cols_eff);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // single cell write merged into the row read back
  row_t mod_row;
  always_comb begin
    mod_row = ram_rdata;
    mod_row[COL_AW'(col_r)] = val_r;
  end

  tlg_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (MAX_ROWS)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tlg_row_next u_row_next (
    .prev_row (prev_r),
    .cur_row  (cur_r),
    .next_row (next_r),
    .cols     (cols_eff),
    .new_row  (new_row)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= DIM_RESET;
      col_count_r <= DIM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_ROW_COUNT: row_count_r <= cfg_wdata;
        REG_COL_COUNT: col_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and ram control
  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_row_r;
        if (clr_row_r == ROW_AW'(MAX_ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_func == FUNC_ADVANCE) ? ST_GEN_P0 : ST_OP_RD;
        end
      end
      ST_OP_RD: begin
        ram_raddr = ROW_AW'(row_r);
        state_nxt = ST_OP_MOD;
      end
      ST_OP_MOD: begin
        // writes of the unused cell code are dropped
        if (func_r == FUNC_WRITE && in_area && val_r <= CELL_OBSTACLE) begin
          ram_we    = 1'b1;
          ram_waddr = ROW_AW'(row_r);
          ram_wdata = mod_row;
        end
        state_nxt = ST_CNT;
      end
      ST_GEN_P0: begin
        ram_raddr = ROW_AW'(rows_eff - DIM_W'(1));
        state_nxt = ST_GEN_P1;
      end
      ST_GEN_P1: begin
        ram_raddr = '0;
        state_nxt = ST_GEN_P2;
      end
      ST_GEN_P2: begin
        ram_raddr = ROW_AW'(gen_nidx0);
        state_nxt = ST_GEN_NX;
      end
      ST_GEN_NX: begin
        state_nxt = ST_GEN_WR;
      end
      ST_GEN_WR: begin
        // new row goes back in place; the read fetches the row below the next
        ram_we    = 1'b1;
        ram_waddr = ROW_AW'(gen_row_r);
        ram_wdata = new_row;
        ram_raddr = ROW_AW'(gen_nidx);
        state_nxt = gen_last ? ST_CNT : ST_GEN_NX;
      end
      ST_CNT: begin
        if (cnt_issue) begin
          ram_raddr = ROW_AW'(cnt_row_r);
        end else if (!rd_vld_r && !grp_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_row_r <= '0;
      gen_row_r <= '0;
      cnt_row_r <= '0;
      rd_vld_r  <= 1'b0;
      grp_vld_r <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) begin
        clr_row_r <= clr_row_r + ROW_AW'(1);
      end
      if (state_r == ST_GEN_P0) begin
        gen_row_r <= '0;
      end else if (state_r == ST_GEN_WR) begin
        gen_row_r <= gen_row_r + DIM_W'(1);
      end
      if (cnt_start) begin
        cnt_row_r <= '0;
      end else if (cnt_issue) begin
        cnt_row_r <= cnt_row_r + DIM_W'(1);
      end
      rd_vld_r  <= cnt_issue;
      grp_vld_r <= rd_vld_r;
    end
  end

  // request capture and generation row window
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      func_r    <= in_func;
      row_r     <= in_row;
      col_r     <= in_col;
      val_r     <= in_val;
      rd_cell_r <= CELL_DEAD;
    end
    if (state_r == ST_OP_MOD && func_r == FUNC_READ && in_area) begin
      rd_cell_r <= ram_rdata[COL_AW'(col_r)];
    end
    case (state_r)
      ST_GEN_P1: prev_r <= ram_rdata;
      ST_GEN_P2: begin
        cur_r      <= ram_rdata;
        keep_r     <= ram_rdata;
        use_keep_r <= 1'b0;
      end
      ST_GEN_NX: begin
        // row zero is already rewritten by the time it wraps in from below
        next_r <= use_keep_r ? keep_r : ram_rdata;
      end
      ST_GEN_WR: begin
        prev_r     <= cur_r;
        cur_r      <= next_r;
        use_keep_r <= (gen_nidx == '0);
      end
      default: ;
    endcase
  end

  // per group alive and dead counts of the row just read
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      alive_part[g] = '0;
      dead_part[g]  = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if ((g * GRP_SIZE + k) < MAX_COLS) begin
          if (DIM_W'(g * GRP_SIZE + k) < cols_eff) begin
            alive_part[g] = alive_part[g]
                          + GRP_CNT_W'(ram_rdata[g * GRP_SIZE + k] == CELL_ALIVE);
            dead_part[g]  = dead_part[g]
                          + GRP_CNT_W'(ram_rdata[g * GRP_SIZE + k] == CELL_DEAD);
          end
        end
      end
    end
  end

  always_comb begin
    alive_sum = '0;
    dead_sum  = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      alive_sum = alive_sum + COUNT_W'(alive_part_r[g]);
      dead_sum  = dead_sum + COUNT_W'(dead_part_r[g]);
    end
  end

  // tally pipeline: row read, group counts, accumulate
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      alive_part_r <= alive_part;
      dead_part_r  <= dead_part;
    end
    if (cnt_start) begin
      alive_acc_r <= '0;
      dead_acc_r  <= '0;
    end else if (grp_vld_r) begin
      alive_acc_r <= alive_acc_r + alive_sum;
      dead_acc_r  <= dead_acc_r + dead_sum;
    end
  end

  // output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {(OUT_W - OUT_USED)'(0), total_cells, dead_acc_r,
                     alive_acc_r, rd_cell_r};
    end
  end

endmodule

FILE: design/tlg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_checker
// port level checks for the toroidal life grid engine, bound to the top
// ----------------------------------------------------------------------------
module tlg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // clearing pass holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request ready during clearing pass");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  // alive plus dead never exceeds the area
  a_counts_fit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[14:2]} + {1'b0, out_tdata[27:15]})
                   <= {1'b0, out_tdata[40:28]})
    else $error("cell counts exceed area");

  // area is never empty and a read never returns the unused code
  a_fields_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[40:28] != 13'd0 && out_tdata[1:0] != 2'd3)
    else $error("bad result fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind toroidal_life_grid_engine tlg_checker u_tlg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
